// File: hw/rtl/bchc_pkg.sv
// Shared types and constants for the button click/hold classifier.
// No dependencies; imported by every module of the block.
`default_nettype none

package bchc_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE_TICKS = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_HOLD_TICKS     = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_HOLD_REPEATS   = 2'd2;

  // reset values
  localparam logic [CfgDataW-1:0] DEBOUNCE_RST = 16'd20;
  localparam logic [CfgDataW-1:0] HOLD_RST     = 16'd1000;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_CLICK = 2'd1,
    EV_HOLD  = 2'd2
  } event_t;

  typedef struct packed {
    logic [CfgDataW-1:0] debounce_ticks;
    logic [CfgDataW-1:0] hold_ticks;
    logic                hold_repeats;
  } cfg_t;

endpackage

`default_nettype wire

// File: hw/rtl/bchc_cfg_regs.sv
// Configuration register file of the click/hold classifier.
// Depends on bchc_pkg.
`default_nettype none

module bchc_cfg_regs
  import bchc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                wr_en,
  input  wire logic [CfgIdxW-1:0]  wr_index,
  input  wire logic [CfgDataW-1:0] wr_data,
  output cfg_t                     cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        CFG_DEBOUNCE_TICKS: cfg_nxt.debounce_ticks = wr_data;
        CFG_HOLD_TICKS:     cfg_nxt.hold_ticks     = wr_data;
        CFG_HOLD_REPEATS:   cfg_nxt.hold_repeats   = wr_data[0];
        default:            cfg_nxt = cfg_r;  // unmapped index: ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks <= DEBOUNCE_RST;
      cfg_r.hold_ticks     <= HOLD_RST;
      cfg_r.hold_repeats   <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// File: hw/rtl/bchc_core.sv
// Per-tick state and classification logic: counters, edge judging, hold test.
// Depends on bchc_pkg.
`default_nettype none

module bchc_core
  import bchc_pkg::*;
#(
  parameter int unsigned TICK_COUNT_WIDTH = 16
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   step,
  input  wire logic   level,
  input  wire logic   cancel_request,
  input  wire cfg_t   cfg,
  output event_t      event_res
);

  localparam int unsigned CmpW =
    (TICK_COUNT_WIDTH > CfgDataW) ? TICK_COUNT_WIDTH : CfgDataW;

  logic                        last_level_r, last_level_nxt;
  logic [TICK_COUNT_WIDTH-1:0] since_press_r, since_press_nxt;
  logic [TICK_COUNT_WIDTH-1:0] since_release_r, since_release_nxt;
  logic                        hold_done_r, hold_done_nxt;
  logic                        hold_cancelled_r, hold_cancelled_nxt;

  logic [TICK_COUNT_WIDTH-1:0] press_adv, release_adv;
  logic [CmpW-1:0]             press_x, release_x, deb_x, hold_x;
  logic                        press_edge, release_edge;
  logic                        press_ok, click;
  logic                        hold_cancel_mid, hold_done_mid, hold_fire;

  always_comb begin
    // saturating advance
    press_adv   = (&since_press_r)   ? since_press_r   : since_press_r + 1'b1;
    release_adv = (&since_release_r) ? since_release_r : since_release_r + 1'b1;

    release_x = CmpW'(release_adv);
    deb_x     = CmpW'(cfg.debounce_ticks);
    hold_x    = CmpW'(cfg.hold_ticks);

    press_edge   = !level && last_level_r;
    release_edge = level && !last_level_r;

    press_ok = press_edge && (release_x > deb_x);
    click    = release_edge && (CmpW'(press_adv) > deb_x) && !hold_done_r;

    since_press_nxt   = press_ok ? '0 : press_adv;
    since_release_nxt = click    ? '0 : release_adv;
    hold_done_mid     = press_ok ? 1'b0 : hold_done_r;
    hold_cancel_mid   = press_ok ? 1'b0 : hold_cancelled_r;

    press_x   = CmpW'(since_press_nxt);
    hold_fire = !level && (press_x > hold_x) && !hold_cancel_mid &&
                (cfg.hold_repeats || !hold_done_mid);

    hold_done_nxt      = hold_done_mid || hold_fire;
    hold_cancelled_nxt = hold_cancel_mid || cancel_request;
    last_level_nxt     = level;

    // click needs a release, hold needs a press level: never both
    if (hold_fire) begin
      event_res = EV_HOLD;
    end else if (click) begin
      event_res = EV_CLICK;
    end else begin
      event_res = EV_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_level_r     <= 1'b1;
      since_press_r    <= '0;
      since_release_r  <= '0;
      hold_done_r      <= 1'b0;
      hold_cancelled_r <= 1'b0;
    end else if (step) begin
      last_level_r     <= last_level_nxt;
      since_press_r    <= since_press_nxt;
      since_release_r  <= since_release_nxt;
      hold_done_r      <= hold_done_nxt;
      hold_cancelled_r <= hold_cancelled_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/bchc_out_stage.sv
// Result register with valid/stall handshake toward the consumer.
// Depends on bchc_pkg.
`default_nettype none

module bchc_out_stage
  import bchc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   load,
  input  wire event_t event_in,
  output logic        busy,
  output logic        out_valid,
  input  wire logic   out_stall,
  output event_t      out_event
);

  logic   valid_r, valid_nxt;
  event_t event_r;

  // full and held by the consumer: cannot take a new item
  assign busy = valid_r && out_stall;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      event_r <= event_in;
    end
  end

  assign out_valid = valid_r;
  assign out_event = event_r;

endmodule

`default_nettype wire

// File: hw/rtl/button_click_hold_classifier.sv
// Top level of the button click/hold classifier.
// Depends on bchc_pkg, bchc_cfg_regs, bchc_core, bchc_out_stage.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall  in_level, in_cancel_request
//   out_     output     out_valid/out_stall  out_event_res (0 none, 1 click, 2 hold)
//   cfg_     input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item per clock. The tick state (counters, flags, last level) updates at
// the edge an item is taken, and its event is loaded into the result register
// at that same edge, so out_valid shows it from the next cycle. Throughput is
// limited only by the result register: in_stall is high only while that
// register is full and out_stall holds it.
// Reset (rst_n low, synchronous) loads the default config and idle state.
// Config writes are always ready.
`default_nettype none

module button_click_hold_classifier
  import bchc_pkg::*;
#(
  parameter int unsigned TICK_COUNT_WIDTH = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // item input
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                in_level,
  input  wire logic                in_cancel_request,
  // result output
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [1:0]               out_event_res,
  // config writes
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data
);

  cfg_t   cfg;
  event_t core_event;
  event_t res_event;
  logic   out_busy;
  logic   accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_busy;
  assign accept    = in_valid && !out_busy;

  bchc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  bchc_core #(
    .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
  ) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (accept),
    .level          (in_level),
    .cancel_request (in_cancel_request),
    .cfg            (cfg),
    .event_res      (core_event)
  );

  bchc_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .event_in  (core_event),
    .busy      (out_busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_event (res_event)
  );

  assign out_event_res = res_event;

endmodule

`default_nettype wire

// File: verif/button_click_hold_classifier_tb.sv
// Self-checking testbench for button_click_hold_classifier.
// Depends on bchc_pkg and the RTL; a cycle-level tick predictor checks every event.
`timescale 1ns / 1ps

module button_click_hold_classifier_tb;
  import bchc_pkg::*;

  localparam int TickW      = 16;
  localparam int RandTicks  = 1350;
  localparam int StallLimit = 2000;  // cycles with no handshake of any kind
  localparam int LongRun    = 200;   // held press far short of a max threshold

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // input item channel
  logic in_valid          = 1'b0;
  logic in_stall;
  logic in_level          = 1'b1;
  logic in_cancel_request = 1'b0;

  // result channel
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_event_res;

  // config write channel
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = CFG_DEBOUNCE_TICKS;
  logic [CfgDataW-1:0] cfg_data  = '0;

  // random idling on both sides; cleared for the long no-idle stretch
  bit gaps_on = 1'b1;

  // predictor state, own copy of the block's tick state and registers
  logic [CfgDataW-1:0] dbnc_ticks;
  logic [CfgDataW-1:0] hold_thresh;
  logic                repeat_mode;
  logic                prev_level;
  logic [TickW-1:0]    press_age;
  logic [TickW-1:0]    release_age;
  logic                hold_fired;
  logic                hold_blocked;

  event_t pending_events[$];

  int error_count  = 0;
  int ticks_taken  = 0;
  int events_seen  = 0;
  int clicks_seen  = 0;
  int holds_seen   = 0;
  int cfg_writes   = 0;
  int idle_cycles  = 0;

  button_click_hold_classifier #(
    .TICK_COUNT_WIDTH(TickW)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_level         (in_level),
    .in_cancel_request(in_cancel_request),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_res    (out_event_res),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // One tick of the classifier. Order matters: counters advance first, then
  // edges are judged, then the hold test, then level and cancel are latched.
  function automatic event_t classify_tick(logic lvl, logic cancel);
    event_t ev;
    logic   clicked;
    ev      = EV_NONE;
    clicked = 1'b0;
    // saturating tick counters
    if (!(&press_age))   press_age   = press_age + 1'b1;
    if (!(&release_age)) release_age = release_age + 1'b1;
    if (!lvl && prev_level) begin
      // press edge: only honored once the debounce gap since release has passed
      if (release_age > dbnc_ticks) begin
        press_age    = '0;
        hold_fired   = 1'b0;
        hold_blocked = 1'b0;
      end
    end else if (lvl && !prev_level) begin
      // release edge: a click unless too short or a hold already fired
      if (press_age > dbnc_ticks && !hold_fired) begin
        release_age = '0;
        clicked     = 1'b1;
      end
    end
    if (clicked) ev = EV_CLICK;
    // hold overrides a click on the same tick (cannot coincide in practice)
    if (!lvl && press_age > hold_thresh && !hold_blocked && (repeat_mode || !hold_fired)) begin
      ev         = EV_HOLD;
      hold_fired = 1'b1;
    end
    prev_level = lvl;
    // cancel takes effect from the next tick on, even on a press tick
    if (cancel) hold_blocked = 1'b1;
    return ev;
  endfunction

  // Monitor: results are checked before new expectations are queued, so an
  // unexpected result is never matched against an item of the same edge.
  always @(posedge clk) begin
    event_t want;
    if (!rst_n) begin
      dbnc_ticks   = DEBOUNCE_RST;
      hold_thresh  = HOLD_RST;
      repeat_mode  = 1'b0;
      prev_level   = 1'b1;
      press_age    = '0;
      release_age  = '0;
      hold_fired   = 1'b0;
      hold_blocked = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_events.size() == 0) begin
          $display("%0t: unexpected event, actual %0d", $time, out_event_res);
          error_count++;
        end else begin
          want = pending_events.pop_front();
          events_seen++;
          if (out_event_res !== want) begin
            $display("%0t: event mismatch, expected %0d (%s), actual %0d",
                     $time, want, want.name(), out_event_res);
            error_count++;
          end
          if (want == EV_CLICK) clicks_seen++;
          if (want == EV_HOLD) holds_seen++;
        end
      end
      if (in_valid && !in_stall) begin
        pending_events.push_back(classify_tick(in_level, in_cancel_request));
        ticks_taken++;
      end
      if (cfg_valid && cfg_ready) begin
        cfg_writes++;
        case (cfg_index)
          CFG_DEBOUNCE_TICKS: dbnc_ticks  = cfg_data;
          CFG_HOLD_TICKS:     hold_thresh = cfg_data;
          CFG_HOLD_REPEATS:   repeat_mode = cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // result-side back-pressure
  always @(posedge clk) begin
    out_stall <= gaps_on && ($urandom_range(99) < 15);
  end

  // watchdog: a hung handshake ends the run
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
        $display("%0t: no handshake for %0d cycles", $time, StallLimit);
        $display("== FAIL ==");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Send one tick. in_valid is left high on return so back-to-back items
  // need no second assignment in the same step; pauses lower it themselves.
  task automatic send_tick(logic lvl, logic cancel);
    while (gaps_on && $urandom_range(99) < 15) begin
      in_valid          <= 1'b0;
      in_level          <= 1'($urandom);
      in_cancel_request <= 1'($urandom);
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_level          <= lvl;
    in_cancel_request <= cancel;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_run(logic lvl, logic cancel, int count);
    repeat (count) send_tick(lvl, cancel);
  endtask

  // Stop sending and let every outstanding event come back. The first edge
  // lets the monitor queue the last item before the queue is looked at.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_events.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Write all three registers while idle.
  task automatic configure(logic [CfgDataW-1:0] dbnc, logic [CfgDataW-1:0] hold, logic rep);
    logic [CfgDataW-1:0] vals[3];
    logic [CfgIdxW-1:0]  idxs[3];
    wait_drained();
    vals = '{dbnc, hold, {{(CfgDataW-1){1'b0}}, rep}};
    idxs = '{CFG_DEBOUNCE_TICKS, CFG_HOLD_TICKS, CFG_HOLD_REPEATS};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idxs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // Reset config: counters start at zero, so early presses and releases
  // fall inside the debounce window and are ignored.
  task automatic test_power_up();
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);
  endtask

  // Single-hold mode: hold once then no click, clean click, short press,
  // cancel raised on the press tick itself.
  task automatic test_single_mode();
    configure(16'd2, 16'd3, 1'b0);
    send_run(1'b0, 1'b0, 6);   // press, hold fires on the 5th tick only
    send_run(1'b1, 1'b0, 4);   // release after hold: no click
    send_run(1'b0, 1'b0, 3);
    send_run(1'b1, 1'b0, 4);   // click
    send_tick(1'b0, 1'b1);     // press with cancel on the same tick
    send_run(1'b0, 1'b0, 5);   // hold suppressed
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);     // bounce: press edge rejected, release is a click
    send_tick(1'b1, 1'b0);
  endtask

  // Repeat mode: hold on every tick past the threshold until cancelled, then silent.
  task automatic test_repeat_mode();
    configure(16'd0, 16'd1, 1'b1);
    send_run(1'b1, 1'b0, 2);
    send_run(1'b0, 1'b0, 4);
    send_tick(1'b0, 1'b1);     // last hold; cancel applies from next tick
    send_run(1'b0, 1'b0, 2);
    send_tick(1'b1, 1'b0);
  endtask

  // Thresholds at the top of their range, then at zero. Run with no idling
  // on either side.
  task automatic test_wide_thresholds();
    configure(16'd0, 16'hFFFF, 1'b1);
    gaps_on = 1'b0;
    send_run(1'b1, 1'b0, 2);
    send_run(1'b0, 1'b0, LongRun);   // long press, hold threshold out of reach
    configure(16'hFFFF, 16'hFFFF, 1'b1);
    send_tick(1'b1, 1'b0);           // release: press age not above debounce
    send_tick(1'b0, 1'b0);           // press rejected, release age too small
    configure(16'd0, 16'd0, 1'b0);
    send_run(1'b1, 1'b0, 2);
    send_run(1'b0, 1'b0, 3);         // zero thresholds: hold right after press
    send_tick(1'b1, 1'b0);
    gaps_on = 1'b1;
  endtask

  // Random part: mostly press/hold/release sequences timed around the
  // current thresholds, with some bouncing noise and sparse cancels.
  task automatic test_random();
    int sent;
    int phase_end;
    int dbnc;
    int hold;
    int rel_len;
    int press_len;
    sent = 0;
    while (sent < RandTicks) begin
      dbnc = ($urandom_range(9) < 8) ? $urandom_range(0, 6) : $urandom_range(30, 60);
      hold = ($urandom_range(9) < 7) ? $urandom_range(0, 12) : $urandom_range(20, 60);
      configure(16'(dbnc), 16'(hold), 1'($urandom));
      phase_end = sent + $urandom_range(120, 220);
      while (sent < phase_end) begin
        if ($urandom_range(9) < 8) begin
          rel_len   = $urandom_range(0, dbnc + 3);
          press_len = $urandom_range(0, hold + 6);
          repeat (rel_len) send_tick(1'b1, 1'($urandom_range(9) == 0));
          repeat (press_len) send_tick(1'b0, 1'($urandom_range(9) == 0));
          sent += rel_len + press_len;
        end else begin
          rel_len = $urandom_range(1, 8);
          repeat (rel_len) send_tick(1'($urandom), 1'($urandom_range(3) == 0));
          sent += rel_len;
        end
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_power_up();
    test_single_mode();
    test_repeat_mode();
    test_wide_thresholds();
    test_random();

    wait_drained();
    repeat (2) @(posedge clk);
    if (pending_events.size() != 0) begin
      $display("%0t: %0d events never arrived", $time, pending_events.size());
      error_count++;
    end

    $display("Ticks: %0d, events checked: %0d (%0d clicks, %0d holds)",
             ticks_taken, events_seen, clicks_seen, holds_seen);
    $display("Register writes: %0d, mismatches: %0d", cfg_writes, error_count);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: button_click_hold_classifier.f
hw/rtl/bchc_pkg.sv
hw/rtl/bchc_cfg_regs.sv
hw/rtl/bchc_core.sv
hw/rtl/bchc_out_stage.sv
hw/rtl/button_click_hold_classifier.sv
verif/button_click_hold_classifier_tb.sv
